>>> hdl/ntpf_pkg.sv
// ----------------------------------------------------------------------------
// ntpf_pkg
// Shared constants, types and control bundles of the NTP offset filter.
// ----------------------------------------------------------------------------
package ntpf_pkg;

  // History ring
  localparam int HIST_DEPTH = 8;
  localparam int PTR_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int THR_W      = 4;
  localparam int LCK_W      = (CNT_W > THR_W) ? CNT_W : THR_W;

  // Arithmetic constants
  localparam logic [29:0] NS_PER_SEC       = 30'd1000000000;
  localparam logic [6:0]  MIN_PACKET_BYTES = 7'd32;

  // Register map (word index taken from paddr[2])
  localparam logic REG_MAX_RTT  = 1'b0;
  localparam logic REG_LOCK_THR = 1'b1;

  localparam logic [31:0]      MAX_RTT_RESET  = 32'd1000000000;
  localparam logic [THR_W-1:0] LOCK_THR_RESET = 4'd3;

  // Multiply sequence: step 0..5 issues a product, step 6 drains the last one
  localparam logic [2:0] MUL_LAST = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPAN,
    ST_CHECK,
    ST_HALF,
    ST_OFFSET,
    ST_WRITE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    PH_NONE,
    PH_SPAN,
    PH_CHECK,
    PH_HALF,
    PH_OFFSET
  } phase_t;

  // Control from the sequencer to the arithmetic unit
  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       acc_en;
    logic [2:0] acc_sel;
    phase_t     phase;
  } arith_ctl_t;

  // One history entry / candidate moving down the cell chain
  typedef struct packed {
    logic signed [63:0] off;
    logic signed [63:0] disp;
  } cand_t;

  // Per-cell control
  typedef struct packed {
    logic wr_en;
    logic live;
  } cell_ctl_t;

endpackage

>>> hdl/ntpf_arith.sv
// ----------------------------------------------------------------------------
// ntpf_arith
// Timestamp conversion, reply check and offset/dispersion math with one shared multiplier.
// ----------------------------------------------------------------------------
module ntpf_arith (
  input  logic                clk,
  input  ntpf_pkg::arith_ctl_t ctl,
  input  logic [263:0]        din,         // item fields, see top level
  input  logic [31:0]         max_rtt,
  output ntpf_pkg::cand_t     res,         // offset and dispersion
  output logic                reject
);
  import ntpf_pkg::*;

  logic [31:0] sec_q [0:2];
  logic [31:0] frac_q [0:2];
  logic [62:0] t4_q;
  logic [6:0]  len_q;

  logic [31:0] mul_op;
  logic [61:0] prod;
  logic [61:0] sec_prod;
  logic [62:0] ts [0:2];
  logic [62:0] stamp_sum;

  logic [63:0] rtt;
  logic [63:0] span;
  logic [63:0] t3m4;
  logic [63:0] delay;
  logic [63:0] disp;
  logic [63:0] off;
  logic        rej;

  // Capture the item
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sec_q[0]  <= din[31:0];
      frac_q[0] <= din[63:32];
      sec_q[1]  <= din[95:64];
      frac_q[1] <= din[127:96];
      sec_q[2]  <= din[159:128];
      frac_q[2] <= din[191:160];
      t4_q      <= din[254:192];
      len_q     <= din[261:255];
    end
  end

  // Operand select: even steps take seconds, odd steps fractions
  always_comb begin
    case (ctl.mul_sel)
      3'd0:    mul_op = sec_q[0];
      3'd1:    mul_op = frac_q[0];
      3'd2:    mul_op = sec_q[1];
      3'd3:    mul_op = frac_q[1];
      3'd4:    mul_op = sec_q[2];
      3'd5:    mul_op = frac_q[2];
      default: mul_op = 32'd0;
    endcase
  end

  // Shared 32x30 multiplier, registered
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= {30'd0, mul_op} * {32'd0, NS_PER_SEC};
    end
  end

  // seconds*1e9 + (fraction*1e9 >> 32)
  assign stamp_sum = {1'b0, sec_prod} + {33'd0, prod[61:32]};

  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      if (!ctl.acc_sel[0]) begin
        sec_prod <= prod;
      end else begin
        case (ctl.acc_sel[2:1])
          2'd0:    ts[0] <= stamp_sum;
          2'd1:    ts[1] <= stamp_sum;
          default: ts[2] <= stamp_sum;
        endcase
      end
    end
  end

  // Round trip, remote span, offset and dispersion in four steps
  always_ff @(posedge clk) begin
    case (ctl.phase)
      PH_SPAN: begin
        rtt  <= {1'b0, t4_q} - {1'b0, ts[0]};
        span <= {1'b0, ts[2]} - {1'b0, ts[1]};
        t3m4 <= {1'b0, ts[2]} - {1'b0, t4_q};
      end
      PH_CHECK: begin
        rej   <= (len_q < MIN_PACKET_BYTES) || rtt[63] || (rtt > {32'd0, max_rtt});
        delay <= rtt - span;
      end
      PH_HALF: begin
        // halve, truncating toward zero
        disp <= 64'($signed(delay + {63'd0, delay[63]}) >>> 1);
      end
      PH_OFFSET: begin
        off <= t3m4 + disp;
      end
      default: begin
      end
    endcase
  end

  assign res.off  = $signed(off);
  assign res.disp = $signed(disp);
  assign reject   = rej;

endmodule

>>> hdl/ntpf_cell.sv
// ----------------------------------------------------------------------------
// ntpf_cell
// One history entry plus one stage of the minimum-dispersion scan.
// ----------------------------------------------------------------------------
module ntpf_cell (
  input  logic                 clk,
  input  ntpf_pkg::cell_ctl_t  ctl,
  input  ntpf_pkg::cand_t      wr,
  input  ntpf_pkg::cand_t      cand_in,
  output ntpf_pkg::cand_t      cand_out
);
  import ntpf_pkg::*;

  cand_t entry;

  // Entry storage
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      entry <= wr;
    end
  end

  // Strictly lower dispersion replaces the candidate, so earlier winners hold ties
  always_ff @(posedge clk) begin
    if (ctl.live && (entry.disp < cand_in.disp)) begin
      cand_out <= entry;
    end else begin
      cand_out <= cand_in;
    end
  end

endmodule

>>> hdl/ntp_offset_min_dispersion_filter.sv
// ----------------------------------------------------------------------------
// ntp_offset_min_dispersion_filter
// NTP reply filter: converts timestamps, rejects bad replies, keeps a ring of
// offsets and reports the offset of the lowest-dispersion entry.
// ----------------------------------------------------------------------------
// One reply is processed at a time. An accepted reply passes through the six
// timestamp products on the single shared multiplier, the add/compare steps
// (span, check, half, offset), one ring write and the walk of the candidate
// down the cell chain, and then loads the output register. A rejected reply
// skips the offset step, the write and the walk. The input side is ready again
// the cycle after the output register is loaded, even while that result still
// waits for m_tready.
// History storage has no reset; only entries already written are compared.
module ntp_offset_min_dispersion_filter (
  input  logic         clk,
  input  logic         rst,
  // input items
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [263:0] s_tdata,   // origin_seconds, origin_fraction, receive_seconds,
                                  // receive_fraction, transmit_seconds,
                                  // transmit_fraction, arrival_time_ns[62:0],
                                  // packet_length[6:0], zero pad[1:0]
  // results
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // current_offset_ns
  output logic [1:0]   m_tuser,   // locked, accepted
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ntpf_pkg::*;

  state_t state, state_next;

  logic [31:0]      max_rtt;
  logic [THR_W-1:0] lock_threshold;

  logic [2:0]       mul_step;
  logic [PTR_W-1:0] scan_cnt;
  logic [PTR_W-1:0] write_pos;
  logic [CNT_W-1:0] stored_count;
  logic [63:0]      cur_offset;
  logic             lock_flag;

  arith_ctl_t actl;
  cand_t      calc;
  logic       reject;
  cand_t      chain [0:HIST_DEPTH];
  logic       out_free;
  logic       out_load;
  logic       lock_hit;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_rtt        <= MAX_RTT_RESET;
      lock_threshold <= LOCK_THR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_LOCK_THR) begin
        lock_threshold <= pwdata[THR_W-1:0];
      end else begin
        max_rtt <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_LOCK_THR) ? {{(32-THR_W){1'b0}}, lock_threshold} : max_rtt;

  // Arithmetic unit
  ntpf_arith u_arith (
    .clk     (clk),
    .ctl     (actl),
    .din     (s_tdata),
    .max_rtt (max_rtt),
    .res     (calc),
    .reject  (reject)
  );

  // Cell chain: the new entry enters cell 0 and moves one cell per cycle
  assign chain[0] = calc;

  for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
    cell_ctl_t cctl;
    assign cctl.wr_en = (state == ST_WRITE) && (write_pos == PTR_W'(i));
    assign cctl.live  = (CNT_W'(i) < stored_count);

    ntpf_cell u_cell (
      .clk      (clk),
      .ctl      (cctl),
      .wr       (calc),
      .cand_in  (chain[i]),
      .cand_out (chain[i+1])
    );
  end

  assign out_free = !m_tvalid || m_tready;
  assign lock_hit = lock_flag || (LCK_W'(stored_count) >= LCK_W'(lock_threshold));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_MUL;
      ST_MUL:    if (mul_step == MUL_LAST) state_next = ST_SPAN;
      ST_SPAN:   state_next = ST_CHECK;
      ST_CHECK:  state_next = ST_HALF;
      ST_HALF:   state_next = reject ? ST_FINISH : ST_OFFSET;
      ST_OFFSET: state_next = ST_WRITE;
      ST_WRITE:  state_next = ST_SCAN;
      ST_SCAN:   if (scan_cnt == PTR_W'(HIST_DEPTH - 1)) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready     = 1'b0;
    out_load     = 1'b0;
    actl.load    = 1'b0;
    actl.mul_en  = 1'b0;
    actl.mul_sel = mul_step;
    actl.acc_en  = 1'b0;
    actl.acc_sel = mul_step - 3'd1;
    actl.phase   = PH_NONE;
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        actl.load = s_tvalid;
      end
      ST_MUL: begin
        actl.mul_en = (mul_step != MUL_LAST);
        actl.acc_en = (mul_step != 3'd0);
      end
      ST_SPAN:   actl.phase = PH_SPAN;
      ST_CHECK:  actl.phase = PH_CHECK;
      ST_HALF:   actl.phase = PH_HALF;
      ST_OFFSET: actl.phase = PH_OFFSET;
      ST_FINISH: out_load = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_step <= 3'd0;
      scan_cnt <= '0;
    end else begin
      mul_step <= (state == ST_MUL) ? mul_step + 3'd1 : 3'd0;
      scan_cnt <= (state == ST_SCAN) ? scan_cnt + PTR_W'(1) : '0;
    end
  end

  // Ring pointer, fill count, held offset and lock
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos    <= '0;
      stored_count <= '0;
      cur_offset   <= '0;
      lock_flag    <= 1'b0;
    end else begin
      if (state == ST_WRITE) begin
        write_pos <= (write_pos == PTR_W'(HIST_DEPTH - 1)) ? '0 : write_pos + PTR_W'(1);
        if (stored_count < CNT_W'(HIST_DEPTH)) begin
          stored_count <= stored_count + CNT_W'(1);
        end
      end
      if (out_load && !reject) begin
        cur_offset <= chain[HIST_DEPTH].off;
        lock_flag  <= lock_hit;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (reject) begin
        m_tdata    <= cur_offset;
        m_tuser[0] <= lock_flag;
      end else begin
        m_tdata    <= chain[HIST_DEPTH].off;
        m_tuser[0] <= lock_hit;
      end
      m_tuser[1] <= !reject;
    end
  end

  // Checks
  a_lock_sticky : assert property (@(posedge clk) disable iff (rst)
    lock_flag |=> lock_flag)
    else $error("lock flag dropped without reset");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(HIST_DEPTH))
    else $error("fill count above ring depth");

  a_ptr_follows_count : assert property (@(posedge clk) disable iff (rst)
    (stored_count < CNT_W'(HIST_DEPTH)) |-> (CNT_W'(write_pos) == stored_count))
    else $error("ring pointer out of step with fill count");

  a_accept_has_entry : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (stored_count != '0))
    else $error("accepted result with empty ring");

endmodule

>>> dv/ntp_offset_min_dispersion_filter_tb.sv
// ----------------------------------------------------------------------------
// ntp_offset_min_dispersion_filter_tb
// Self-checking bench for the NTP offset filter. Replies go in on the input
// stream and a scoreboard model of the offset ring predicts every result.
// Each result on the output stream is checked against the oldest prediction.
// Directed replies cover the window edges, short and negative round trips,
// dispersion ties and the lock threshold. Random traffic then runs under
// three idle mixes, plus an output stall and a drained input pause.
// ----------------------------------------------------------------------------
module ntp_offset_min_dispersion_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ntpf_pkg::*;

  localparam logic [63:0] NS_PER_S     = 64'd1000000000;
  localparam logic [31:0] RTT_ALL_ONES = 32'hFFFF_FFFF;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          MAX_REPORTS  = 10;

  typedef struct {
    logic [31:0] org_s;
    logic [31:0] org_f;
    logic [31:0] rcv_s;
    logic [31:0] rcv_f;
    logic [31:0] xmt_s;
    logic [31:0] xmt_f;
    logic [62:0] arrival;
    logic [6:0]  pkt_len;
  } ntp_reply_t;

  typedef struct {
    logic signed [63:0] offset;
    logic               locked;
    logic               accepted;
  } filter_result_t;

  // DUT signals
  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [263:0] s_tdata  = '0;  // org_s, org_f, rcv_s, rcv_f, xmt_s, xmt_f,
                                // arrival[62:0], pkt_len[6:0], pad[1:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;        // current_offset_ns
  logic [1:0]   m_tuser;        // locked, accepted
  logic         psel     = 1'b0;
  logic         penable  = 1'b0;
  logic         pwrite   = 1'b0;
  logic [2:0]   paddr    = '0;
  logic [31:0]  pwdata   = '0;
  logic [31:0]  prdata;
  logic         pready;

  // Scoreboard model of the filter
  logic signed [63:0] ring_offset [HIST_DEPTH];
  logic signed [63:0] ring_disp   [HIST_DEPTH];
  int unsigned        ring_wr        = 0;
  int unsigned        ring_fill      = 0;
  logic signed [63:0] cur_offset_ns  = '0;
  logic               lock_seen      = 1'b0;
  logic [31:0]        cfg_max_rtt    = MAX_RTT_RESET;
  logic [THR_W-1:0]   cfg_lock_thr   = LOCK_THR_RESET;

  filter_result_t expected_results [$];
  int             mismatches    = 0;
  int             cycle_count   = 0;
  int             src_idle_pct  = 0;
  int             sink_idle_pct = 0;
  int             rx_hold_left  = 0;
  ntp_reply_t     last_exchange;
  bit             have_exchange = 1'b0;

  ntp_offset_min_dispersion_filter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // NTP seconds/fraction to nanoseconds
  function automatic longint stamp_ns(input logic [31:0] secs, input logic [31:0] frac);
    logic [63:0] whole;
    logic [63:0] part;
    whole = {32'd0, secs} * NS_PER_S;
    part  = ({32'd0, frac} * NS_PER_S) >> 32;
    return longint'(whole + part);
  endfunction

  function automatic logic [263:0] pack_reply(input ntp_reply_t r);
    return {2'b00, r.pkt_len, r.arrival, r.xmt_f, r.xmt_s, r.rcv_f, r.rcv_s,
            r.org_f, r.org_s};
  endfunction

  // Advance the model by one reply and return the result it produces
  function automatic filter_result_t filter_reply(input ntp_reply_t r);
    filter_result_t res;
    longint t1, t2, t3, t4, rtt, dly, dsp, off, low_disp;
    int i;
    t1 = stamp_ns(r.org_s, r.org_f);
    t2 = stamp_ns(r.rcv_s, r.rcv_f);
    t3 = stamp_ns(r.xmt_s, r.xmt_f);
    t4 = longint'({1'b0, r.arrival});
    rtt = t4 - t1;
    res.accepted = 1'b0;
    if (r.pkt_len >= MIN_PACKET_BYTES && rtt >= 0 &&
        rtt <= longint'({32'd0, cfg_max_rtt})) begin
      dly = rtt - (t3 - t2);
      dsp = dly / 2;
      off = t3 + dsp - t4;
      ring_offset[ring_wr] = off;
      ring_disp[ring_wr]   = dsp;
      ring_wr = (ring_wr + 1) % HIST_DEPTH;
      if (ring_fill < HIST_DEPTH) ring_fill++;
      // newest entry wins ties, then the lowest ring slot
      cur_offset_ns = off;
      low_disp = dsp;
      for (i = 0; i < ring_fill; i++) begin
        if (ring_disp[i] < low_disp) begin
          low_disp = ring_disp[i];
          cur_offset_ns = ring_offset[i];
        end
      end
      if (!lock_seen && ring_fill >= cfg_lock_thr) lock_seen = 1'b1;
      res.accepted = 1'b1;
    end
    res.offset = cur_offset_ns;
    res.locked = lock_seen;
    return res;
  endfunction

  // Reply whose arrival lies rtt after the origin stamp (clamped at zero)
  function automatic ntp_reply_t exchange(input logic [31:0] org_s, input logic [31:0] org_f,
                                          input logic [31:0] rcv_s, input logic [31:0] rcv_f,
                                          input logic [31:0] xmt_s, input logic [31:0] xmt_f,
                                          input longint rtt, input logic [6:0] len);
    ntp_reply_t r;
    longint t_arr;
    r.org_s = org_s;
    r.org_f = org_f;
    r.rcv_s = rcv_s;
    r.rcv_f = rcv_f;
    r.xmt_s = xmt_s;
    r.xmt_f = xmt_f;
    t_arr = stamp_ns(org_s, org_f) + rtt;
    if (t_arr < 0) t_arr = 0;
    r.arrival = t_arr[62:0];
    r.pkt_len = len;
    return r;
  endfunction

  // Mostly well-formed exchanges, some dispersion ties and some noise
  function automatic ntp_reply_t random_reply();
    ntp_reply_t r;
    longint rtt;
    int unsigned pick;
    int unsigned k;
    logic [31:0] srv_s;
    logic [6:0] len;
    pick = $urandom_range(99);
    if (pick < 10) begin
      r.org_s   = $urandom;
      r.org_f   = $urandom;
      r.rcv_s   = $urandom;
      r.rcv_f   = $urandom;
      r.xmt_s   = $urandom;
      r.xmt_f   = $urandom;
      r.arrival = 63'({$urandom, $urandom});
      r.pkt_len = 7'($urandom_range(64));
      return r;
    end
    if (pick < 25 && have_exchange) begin
      // same path delay, server clock shifted by whole seconds
      r = last_exchange;
      k = $urandom_range(1, 1000);
      r.rcv_s = r.rcv_s + k;
      r.xmt_s = r.xmt_s + k;
      return r;
    end
    pick = $urandom_range(99);
    if (pick < 70)      rtt = longint'({32'd0, 32'($urandom_range(cfg_max_rtt))});
    else if (pick < 80) rtt = longint'({32'd0, cfg_max_rtt});
    else if (pick < 90) rtt = longint'({32'd0, cfg_max_rtt}) + 1 + $urandom_range(1000);
    else                rtt = -64'sd1 - longint'({32'd0, 32'($urandom_range(1000000))});
    len = ($urandom_range(9) == 0) ? 7'($urandom_range(31)) : 7'($urandom_range(64, 32));
    r.org_s = $urandom;
    srv_s = r.org_s + 32'($urandom_range(200)) - 32'd100;
    r = exchange(r.org_s, $urandom, srv_s, $urandom, srv_s + 32'($urandom_range(1)),
                 $urandom, rtt, len);
    last_exchange = r;
    have_exchange = 1'b1;
    return r;
  endfunction

  // One input transaction; the prediction is queued when it is accepted
  task automatic send_reply(input ntp_reply_t r);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_reply(r);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(filter_reply(r));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // APB write: setup then access phase
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MAX_RTT) cfg_max_rtt = value;
    else                    cfg_lock_thr = value[THR_W-1:0];
    @(posedge clk);
  endtask

  // Reset settings: round trip window edge, short and negative replies
  task automatic test_reset_defaults();
    send_reply(exchange(1000, 0, 1000, 32'h8000_0000, 1000, 32'h8000_1000,
                        1000000000, 48));
    send_reply(exchange(1000, 0, 1000, 32'h8000_0000, 1000, 32'h8000_1000,
                        1000000001, 48));
    send_reply(exchange(1000, 0, 1000, 0, 1000, 32'h0000_1000, 500, 31));
    send_reply(exchange(1000, 0, 1000, 0, 1000, 32'h0000_1000, 500, 0));
    send_reply(exchange(1000, 0, 1000, 0, 1000, 32'h0000_1000, 500, 32));
    send_reply(exchange(1000, 0, 1000, 0, 1000, 32'h0000_1000, -1, 64));
  endtask

  // Threshold above the ring depth: ring wraps, lock never comes
  task automatic test_lock_above_depth();
    wait_drained();
    write_reg(REG_LOCK_THR, 32'd15);
    write_reg(REG_MAX_RTT, 32'd0);
    send_reply(exchange(7, 1, 7, 2, 7, 3, 0, 64));
    send_reply(exchange(7, 1, 7, 2, 7, 3, 1, 64));
    wait_drained();
    write_reg(REG_MAX_RTT, RTT_ALL_ONES);
    send_reply(exchange(0, 0, 0, 0, 0, 0, 0, 64));
    send_reply(exchange('1, '1, '1, '1, '1, '1, longint'({32'd0, RTT_ALL_ONES}), 64));
    send_reply(exchange('1, '1, '1, '1, '1, '1, longint'({32'd0, RTT_ALL_ONES}) + 1, 64));
    // equal dispersion, different offsets: newest wins, then lowest slot
    send_reply(exchange(5000, 0, 5010, 0, 5010, 32'h0100_0000, 2000, 40));
    send_reply(exchange(5000, 0, 5013, 0, 5013, 32'h0100_0000, 2000, 40));
    send_reply(exchange(5000, 0, 5017, 0, 5017, 32'h0100_0000, 2000, 40));
    send_reply(exchange(5000, 0, 5010, 0, 5010, 32'h0100_0000, 4000, 40));
    send_reply(exchange(6000, 9, 6002, 5, 6002, 77, 123456, 33));
  endtask

  // Threshold at the ring depth: next accepted reply locks
  task automatic test_lock_at_depth();
    wait_drained();
    write_reg(REG_LOCK_THR, 32'(HIST_DEPTH));
    send_reply(exchange(9000, 0, 9001, 0, 9001, 32'h0000_4000, 3000, 50));
    send_reply(exchange(9000, 0, 9001, 0, 9001, 32'h0000_4000, 3000, 20));
    send_reply('{org_s: '0, org_f: '0, rcv_s: '0, rcv_f: '0, xmt_s: '0, xmt_f: '0,
                 arrival: '1, pkt_len: 7'd64});
  endtask

  task automatic test_random_traffic(input int n_items, input logic [31:0] max_rtt,
                                     input logic [THR_W-1:0] thr);
    wait_drained();
    write_reg(REG_MAX_RTT, max_rtt);
    write_reg(REG_LOCK_THR, 32'(thr));
    repeat (n_items) send_reply(random_reply());
  endtask

  // Long output stall while the source keeps offering replies
  task automatic test_output_backpressure();
    wait_drained();
    @(negedge clk);
    rx_hold_left = 400;
    @(posedge clk);
    repeat (24) send_reply(random_reply());
  endtask

  // Source stops until every result is back, then resumes
  task automatic test_source_pause();
    repeat (12) send_reply(random_reply());
    wait_drained();
    repeat (12) send_reply(random_reply());
  endtask

  // Output ready: hold-off window first, else random idling
  always @(posedge clk) begin : drive_ready
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Result checking against the oldest prediction
  always @(posedge clk) begin : check_results
    filter_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result offset %0d locked %b accepted %b",
                   $realtime, $signed(m_tdata), m_tuser[0], m_tuser[1]);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata !== want.offset || m_tuser[0] !== want.locked ||
            m_tuser[1] !== want.accepted) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: expected offset %0d locked %b accepted %b, got %0d %b %b",
                     $realtime, want.offset, want.locked, want.accepted,
                     $signed(m_tdata), m_tuser[0], m_tuser[1]);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("** ntp_offset_min_dispersion_filter: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_lock_above_depth();
    test_lock_at_depth();

    src_idle_pct  = 15;
    sink_idle_pct = 61;
    test_random_traffic(540, MAX_RTT_RESET, '0);
    src_idle_pct  = 61;
    sink_idle_pct = 15;
    test_random_traffic(540, RTT_ALL_ONES, 4'd1);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(540, 32'd5000, LOCK_THR_RESET);

    test_output_backpressure();
    test_source_pause();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** ntp_offset_min_dispersion_filter: PASSED **");
    end else begin
      $display("** ntp_offset_min_dispersion_filter: FAILED **");
    end
    $finish;
  end

endmodule
